// File: sv/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Types and constants shared by the decimated PI-D controller modules.
// ----------------------------------------------------------------------------
package dpd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned AccW     = 40;
  localparam int unsigned SumW     = 42;
  localparam int unsigned LogDataW = 64;

  localparam logic [7:0]         DecimationRst = 8'd6;
  localparam logic signed [23:0] GainNowRst    = 24'sd17854;
  localparam logic signed [23:0] GainPrevRst   = -24'sd11333;
  localparam logic signed [23:0] GainRateRst   = 24'sd3128;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDecimation = 2'd0,
    CfgGainNow    = 2'd1,
    CfgGainPrev   = 2'd2,
    CfgGainRate   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] sample;
    logic [11:0] setpoint;
    logic        run;
  } in_item_t;

  typedef struct packed {
    logic        update;
    logic [15:0] duty;
    logic        log_full;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         decimation;
    logic signed [23:0] gain_now;
    logic signed [23:0] gain_prev;
    logic signed [23:0] gain_rate;
  } cfg_t;

  typedef struct packed {
    logic                en;
    logic [LogDataW-1:0] data;
  } log_wr_t;

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SumW-1:0] v);
    logic signed [AccW-1:0] r;
    if ((v[SumW-1:AccW-1] == '0) || (v[SumW-1:AccW-1] == '1)) begin
      r = v[AccW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(AccW-1){1'b0}}};
    end else begin
      r = {1'b0, {(AccW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_duty(input logic signed [AccW-1:0] v);
    logic [15:0] r;
    if (v[AccW-1]) begin
      r = '0;
    end else if (v[AccW-2:16] != '0) begin
      r = '1;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: sv/decimated_pi_d_controller.sv
// ----------------------------------------------------------------------------
// decimated_pi_d_controller
// Decimated PI-D controller with the derivative taken on the measurement.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o     in_item_i  (in_item_t)
//   out      output     out_valid_o / out_stall_i   out_item_o (out_item_t)
//   cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// Each event passes from the input transfer into the input register and
// then through the control law into the result register. A new event is
// taken every cycle unless a stalled result blocks it; law state loops back.
// An asynchronous low reset clears the control state and loads the default
// configuration. A stalled result holds both stages, and an event is still
// taken while a result waits if the input register is free.
// ----------------------------------------------------------------------------
module decimated_pi_d_controller #(
  parameter int unsigned LOG_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dpd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dpd_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dpd_pkg::CfgDataW-1:0] cfg_data_i
);
  import dpd_pkg::*;

  localparam int unsigned IdxW  = $clog2(LOG_DEPTH + 1);
  localparam int unsigned AddrW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  cfg_t             cfg;
  in_item_t         item_q;
  logic             s1_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_fire;
  logic             step;
  logic [AddrW-1:0] log_addr;
  log_wr_t          log_wr;

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign step        = s1_valid_q && advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
  end

  dpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpd_law #(
    .LOG_DEPTH (LOG_DEPTH),
    .IDX_W     (IdxW),
    .ADDR_W    (AddrW)
  ) u_law (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (step),
    .item_i     (item_q),
    .result_o   (out_item_o),
    .log_addr_o (log_addr),
    .log_wr_o   (log_wr)
  );

  dpd_log #(
    .LOG_DEPTH (LOG_DEPTH),
    .ADDR_W    (AddrW)
  ) u_log (
    .clk_i  (clk_i),
    .addr_i (log_addr),
    .wr_i   (log_wr)
  );

endmodule

// File: sv/dpd_cfg.sv
// ----------------------------------------------------------------------------
// dpd_cfg
// Configuration registers: decimation ratio and the three Q16 gains.
// ----------------------------------------------------------------------------
module dpd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [dpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dpd_pkg::CfgDataW-1:0] cfg_data_i,
  output dpd_pkg::cfg_t                cfg_o
);
  import dpd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decimation <= DecimationRst;
      cfg_q.gain_now   <= GainNowRst;
      cfg_q.gain_prev  <= GainPrevRst;
      cfg_q.gain_rate  <= GainRateRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgDecimation: cfg_q.decimation <= cfg_data_i[7:0];
        CfgGainNow:    cfg_q.gain_now   <= $signed(cfg_data_i);
        CfgGainPrev:   cfg_q.gain_prev  <= $signed(cfg_data_i);
        CfgGainRate:   cfg_q.gain_rate  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/dpd_law.sv
// ----------------------------------------------------------------------------
// dpd_law
// Decimation counter, incremental PI law with derivative on measurement,
// capture pointer and the result register.
// ----------------------------------------------------------------------------
module dpd_law #(
  parameter int unsigned LOG_DEPTH = 1024,
  parameter int unsigned IDX_W     = 11,
  parameter int unsigned ADDR_W    = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpd_pkg::cfg_t       cfg_i,
  input  logic                step_i,
  input  dpd_pkg::in_item_t   item_i,
  output dpd_pkg::out_item_t  result_o,
  output logic [ADDR_W-1:0]   log_addr_o,
  output dpd_pkg::log_wr_t    log_wr_o
);
  import dpd_pkg::*;

  logic [7:0]             tick_q, tick_d;
  logic signed [12:0]     prev_err_q, prev_err_d;
  logic signed [AccW-1:0] pi_q, pi_d;
  logic [11:0]            prev_sample_q, prev_sample_d;
  logic signed [AccW-1:0] drive_q, drive_d;
  logic [IDX_W-1:0]       log_idx_q, log_idx_d;
  logic                   log_done_q, log_done_d;
  out_item_t              result_q, result_d;

  logic [8:0]             tick_next;
  logic                   instant;
  logic signed [12:0]     err;
  logic signed [12:0]     diff;
  logic signed [36:0]     prod_now;
  logic signed [36:0]     prod_prev;
  logic signed [36:0]     prod_rate;
  logic signed [SumW-1:0] pi_sum;
  logic signed [SumW-1:0] drive_sum;
  logic [IDX_W-1:0]       log_idx_inc;

  always_comb begin
    tick_next   = {1'b0, tick_q} + 9'd1;
    instant     = !(tick_next < {1'b0, cfg_i.decimation});
    err         = $signed({1'b0, item_i.setpoint}) - $signed({1'b0, item_i.sample});
    diff        = $signed({1'b0, item_i.sample}) - $signed({1'b0, prev_sample_q});
    prod_now    = cfg_i.gain_now * err;
    prod_prev   = cfg_i.gain_prev * prev_err_q;
    prod_rate   = cfg_i.gain_rate * diff;
    pi_sum      = SumW'(pi_q) + SumW'(prod_now) + SumW'(prod_prev);
    log_idx_inc = log_idx_q + IDX_W'(1);

    tick_d        = tick_q;
    prev_err_d    = prev_err_q;
    pi_d          = pi_q;
    prev_sample_d = prev_sample_q;
    drive_d       = drive_q;
    log_idx_d     = log_idx_q;
    log_done_d    = log_done_q;
    log_wr_o.en   = 1'b0;
    drive_sum     = SumW'(sat_acc(pi_sum)) - SumW'(prod_rate);

    result_d.update   = 1'b0;
    result_d.duty     = '0;
    result_d.log_full = log_done_q;

    if (!instant) begin
      tick_d = tick_next[7:0];
    end else begin
      tick_d          = '0;
      result_d.update = 1'b1;
      result_d.duty   = clamp_duty(drive_q);
      if (!item_i.run) begin
        log_idx_d  = '0;
        log_done_d = 1'b0;
        drive_d    = '0;
      end else begin
        pi_d          = sat_acc(pi_sum);
        drive_d       = sat_acc(drive_sum);
        prev_err_d    = err;
        prev_sample_d = item_i.sample;
        if (!log_done_q) begin
          log_wr_o.en = step_i;
          log_idx_d   = log_idx_inc;
          log_done_d  = (log_idx_inc == IDX_W'(LOG_DEPTH));
        end
      end
      result_d.log_full = log_done_d;
    end

    log_wr_o.data = {drive_d, item_i.sample, item_i.setpoint};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= '0;
      prev_err_q    <= '0;
      pi_q          <= '0;
      prev_sample_q <= '0;
      drive_q       <= '0;
      log_idx_q     <= '0;
      log_done_q    <= 1'b0;
    end else if (step_i) begin
      tick_q        <= tick_d;
      prev_err_q    <= prev_err_d;
      pi_q          <= pi_d;
      prev_sample_q <= prev_sample_d;
      drive_q       <= drive_d;
      log_idx_q     <= log_idx_d;
      log_done_q    <= log_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o   = result_q;
  assign log_addr_o = log_idx_q[ADDR_W-1:0];

endmodule

// File: sv/dpd_log.sv
// ----------------------------------------------------------------------------
// dpd_log
// Capture memory holding setpoint, measurement and drive per sampling instant.
// ----------------------------------------------------------------------------
module dpd_log #(
  parameter int unsigned LOG_DEPTH = 1024,
  parameter int unsigned ADDR_W    = 10
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  dpd_pkg::log_wr_t  wr_i
);
  import dpd_pkg::*;

  logic [LogDataW-1:0] mem_q [LOG_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[addr_i] <= wr_i.data;
    end
  end

endmodule
